[rtl/core/lidar_packet_deframer_binner_assert.svh]
// Assertion macros for the lidar packet deframer and binner
`ifndef LIDAR_PACKET_DEFRAMER_BINNER_ASSERT_SVH
`define LIDAR_PACKET_DEFRAMER_BINNER_ASSERT_SVH
`ifndef SYNTHESIS
`define LDB_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LDB_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LDB_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define LDB_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/ldb_pkg.sv]
// Shared types and constants of the lidar packet deframer and binner
`default_nettype none
package ldb_pkg;
    localparam logic       CMD_BYTE     = 1'b0;
    localparam logic       CMD_BIN      = 1'b1;
    localparam logic       KIND_PKT     = 1'b0;
    localparam logic       KIND_BIN     = 1'b1;
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_CSUM    = 2'd1;
    localparam logic [1:0] STAT_DROP    = 2'd2;
    localparam logic       CFG_RNG_MIN  = 1'b0;
    localparam logic       CFG_RNG_MAX  = 1'b1;
    localparam logic [7:0] SYNC_BYTE    = 8'hAA;
    localparam int         HDR_BYTES    = 9;
    localparam int         SAMPLE_START = 13;
    localparam int         BIN_W        = 10;
    localparam logic [15:0] DIV3_MUL    = 16'd43691;
    localparam logic [17:0] DIV100_MUL  = 18'd167773;
    localparam logic [6:0]  CDEG        = 7'd100;
    localparam logic [15:0] RNG_MIN_RST = 16'd600;
    localparam logic [15:0] RNG_MAX_RST = 16'd48000;

    typedef struct packed {
        logic mul;
        logic split;
        logic adv;
    } t_bs_ctl;
endpackage
`default_nettype wire

[rtl/core/ldb_in_if.sv]
// Input channel: serial bytes and bin read commands
`default_nettype none
interface ldb_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;
    logic [8:0] bin_index;
    modport source (output valid, command, rx_byte, bin_index, input ready);
    modport sink (input valid, command, rx_byte, bin_index, output ready);
endinterface
`default_nettype wire

[rtl/core/ldb_out_if.sv]
// Output channel: packet events and bin read answers
`default_nettype none
interface ldb_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [1:0]  packet_status;
    logic [6:0]  samples_accepted;
    logic [31:0] error_total;
    logic        bin_has_range;
    logic [15:0] bin_distance;
    logic [7:0]  bin_intensity;
    modport source (output valid, result_kind, packet_status, samples_accepted, error_total,
                    bin_has_range, bin_distance, bin_intensity, input ready);
    modport sink (input valid, result_kind, packet_status, samples_accepted, error_total,
                  bin_has_range, bin_distance, bin_intensity, output ready);
endinterface
`default_nettype wire

[rtl/core/lidar_packet_deframer_binner.sv]
// Top level of the lidar packet deframer and scan binner
// Usage:
//   i_in carries items: command 0 delivers one serial byte, command 1 reads one
//   scan bin. o_out carries results: a packet event (status, kept samples,
//   checksum error count) when a packet ends or is dropped, or a bin answer.
//   Configuration: i_cfg_we writes i_cfg_data to range min (index 0) or max (1).
// Timing:
//   A byte that ends no packet leaves the block in ST_IDLE, so such bytes go
//   back to back. A bin read answer is loaded from ST_BRD into the output
//   register, a dropped-length event from ST_EMIT after its ninth byte, a
//   bad-checksum event via ST_FIN and ST_EMIT after the last byte. A good packet
//   clears NUM_BINS bins one per cycle, walks samples through ST_SA to ST_SE
//   (three reads of the packet buffer, check, write), then emits from ST_EMIT.
//   No item is accepted from the end of a packet until its event issues.
// Reset:
//   i_rst_n is synchronous. After reset the bin table is cleared in ST_BOOT,
//   during which no item is accepted; configuration is taken at once.
// Stall:
//   A result waits in the output register while o_out.ready is low; the block
//   takes further items but holds before it would produce the next result.
`default_nettype none
module lidar_packet_deframer_binner #(
    parameter int PACKET_BYTES = 256,
    parameter int NUM_BINS     = 360
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ldb_in_if.sink     i_in,
    ldb_out_if.source  o_out,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    localparam int CW  = $clog2(PACKET_BYTES + 1);
    localparam int AW  = $clog2(PACKET_BYTES);
    localparam int BAW = $clog2(NUM_BINS);
    localparam logic [CW-1:0] PB_C   = CW'(PACKET_BYTES);
    localparam logic [16:0]   PB_17  = 17'(PACKET_BYTES);
    localparam logic [10:0]   NB_11  = 11'(NUM_BINS);
    localparam logic [BAW-1:0] NB_LAST = BAW'(NUM_BINS - 1);
    localparam logic [CW-1:0] HDR_C  = CW'(ldb_pkg::HDR_BYTES);

    typedef enum logic [3:0] {
        ST_BOOT, ST_IDLE, ST_BRD, ST_FIN, ST_CLR, ST_INIT1, ST_INIT2,
        ST_SA, ST_SB, ST_SC, ST_SD, ST_SE, ST_EMIT
    } t_state;

    t_state r_state;

    logic [7:0]  r_store [PACKET_BYTES];
    logic [24:0] r_bins  [NUM_BINS];
    logic [7:0]  r_pq;
    logic [24:0] r_bq;

    logic          r_in_pkt, r_len_known, r_out_valid, r_bidx_ok;
    logic [CW-1:0] r_count, r_exp;
    logic [31:0]   r_err;
    logic [BAW-1:0] r_clr_idx;
    logic [15:0]   r_rng_min, r_rng_max;
    logic [15:0]   r_sum;
    logic [7:0]    r_b0, r_b1, r_len_lo, r_len_hi, r_dl_lo, r_dl_hi, r_st_lo, r_st_hi;
    logic [14:0]   r_num, r_left;
    logic [2:0]    r_step;
    logic [CW:0]   r_at;
    logic [7:0]    r_inten, r_dlo;
    logic [6:0]    r_kept;
    logic [1:0]    r_status;

    logic          r_o_kind, r_o_has;
    logic [1:0]    r_o_status;
    logic [6:0]    r_o_kept;
    logic [31:0]   r_o_err;
    logic [15:0]   r_o_dist;
    logic [7:0]    r_o_inten;

    logic          acc, acc_bin, acc_byte, slot_free, stored, keep, out_load;
    logic [CW-1:0] cnt_after, eff_exp;
    logic [15:0]   len, dl, chk, smp_dist;
    logic [31:0]   div3_prod;
    logic [16:0]   num3;
    logic [1:0]    rem3;
    logic [2:0]    step_c;
    logic [CW:0]   rd_at;
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic          bn_we;
    logic [BAW-1:0] bn_waddr;
    logic [24:0]   bn_wdata;
    logic [10:0]   idx11;
    ldb_pkg::t_bs_ctl bs_ctl;
    logic [ldb_pkg::BIN_W-1:0] bin;

    assign i_in.ready = (r_state == ST_IDLE);
    assign acc        = i_in.valid && i_in.ready;
    assign acc_bin    = acc && (i_in.command == ldb_pkg::CMD_BIN);
    assign acc_byte   = acc && (i_in.command == ldb_pkg::CMD_BYTE);
    assign slot_free  = !r_out_valid || o_out.ready;
    assign out_load   = slot_free && (r_state == ST_EMIT || r_state == ST_BRD);
    assign stored     = r_count < PB_C;
    assign cnt_after  = stored ? r_count + 1'b1 : r_count;
    assign len        = {r_len_hi, r_len_lo};
    assign eff_exp    = r_len_known ? r_exp : len[CW-1:0];
    assign dl         = {r_dl_hi, r_dl_lo};
    assign chk        = r_sum - {8'b0, r_b0} - {8'b0, r_b1};
    assign div3_prod  = {16'b0, dl} * {16'b0, ldb_pkg::DIV3_MUL};
    assign num3       = {2'b0, r_num} * 17'd3;
    assign rem3       = 2'(dl - num3[15:0]);
    assign smp_dist   = {r_pq, r_dlo};
    assign idx11      = {2'b0, i_in.bin_index};
    assign keep       = ({1'b0, bin} < NB_11) && (smp_dist >= r_rng_min) &&
                        (smp_dist <= r_rng_max);

    always_comb begin
        if (r_num == 15'd0) begin
            step_c = 3'd0;
        end else if (r_num == 15'd1) begin
            step_c = 3'd3 + {1'b0, rem3};
        end else if (r_num == 15'd2) begin
            step_c = (rem3 == 2'd2) ? 3'd4 : 3'd3;
        end else begin
            step_c = 3'd3;
        end
    end

    always_comb begin
        unique case (r_state)
            ST_SC:   rd_at = r_at + 1'b1;
            ST_SD:   rd_at = r_at + 2'd2;
            default: rd_at = r_at;
        endcase
    end

    assign st_we    = acc_byte && (r_in_pkt ? stored : (i_in.rx_byte == ldb_pkg::SYNC_BYTE));
    assign st_waddr = r_in_pkt ? r_count[AW-1:0] : '0;

    always_comb begin
        bn_we    = 1'b0;
        bn_waddr = r_clr_idx;
        bn_wdata = '0;
        if (r_state == ST_BOOT || r_state == ST_CLR) begin
            bn_we = 1'b1;
        end else if (r_state == ST_SE && keep) begin
            bn_we    = 1'b1;
            bn_waddr = bin[BAW-1:0];
            bn_wdata = {1'b1, smp_dist, r_inten};
        end
    end

    always_comb begin
        bs_ctl.mul   = (r_state == ST_INIT1);
        bs_ctl.split = (r_state == ST_INIT2);
        bs_ctl.adv   = (r_state == ST_SE);
    end

    ldb_bin_step u_bin_step (
        .i_clk   (i_clk),
        .i_ctl   (bs_ctl),
        .i_start ({r_st_hi, r_st_lo}),
        .i_step  (r_step),
        .o_bin   (bin)
    );

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_waddr] <= i_in.rx_byte;
        end
        r_pq <= r_store[rd_at[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (bn_we) begin
            r_bins[bn_waddr] <= bn_wdata;
        end
        if (acc_bin) begin
            r_bq <= r_bins[idx11[BAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng_min <= ldb_pkg::RNG_MIN_RST;
            r_rng_max <= ldb_pkg::RNG_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ldb_pkg::CFG_RNG_MIN: r_rng_min <= i_cfg_data;
                ldb_pkg::CFG_RNG_MAX: r_rng_max <= i_cfg_data;
                default:              r_rng_min <= r_rng_min;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_BOOT;
            r_in_pkt    <= 1'b0;
            r_len_known <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_exp       <= '0;
            r_err       <= '0;
            r_clr_idx   <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_BOOT, ST_CLR: begin
                    if (r_clr_idx == NB_LAST) begin
                        r_clr_idx <= '0;
                        r_state   <= (r_state == ST_BOOT) ? ST_IDLE : ST_INIT1;
                    end else begin
                        r_clr_idx <= r_clr_idx + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (acc_bin) begin
                        r_bidx_ok <= idx11 < NB_11;
                        r_state   <= ST_BRD;
                    end else if (acc_byte && !r_in_pkt) begin
                        if (i_in.rx_byte == ldb_pkg::SYNC_BYTE) begin
                            r_in_pkt    <= 1'b1;
                            r_len_known <= 1'b0;
                            r_count     <= CW'(1);
                            r_sum       <= {8'b0, i_in.rx_byte};
                            r_b1        <= i_in.rx_byte;
                        end
                    end else if (acc_byte) begin
                        if (stored) begin
                            r_count <= cnt_after;
                            r_sum   <= r_sum + {8'b0, i_in.rx_byte};
                            r_b0    <= r_b1;
                            r_b1    <= i_in.rx_byte;
                            if (r_count == CW'(1))  r_len_lo <= i_in.rx_byte;
                            if (r_count == CW'(2))  r_len_hi <= i_in.rx_byte;
                            if (r_count == CW'(6))  r_dl_lo  <= i_in.rx_byte;
                            if (r_count == CW'(7))  r_dl_hi  <= i_in.rx_byte;
                            if (r_count == CW'(11)) r_st_lo  <= i_in.rx_byte;
                            if (r_count == CW'(12)) r_st_hi  <= i_in.rx_byte;
                        end
                        if (cnt_after >= HDR_C) begin
                            if (!r_len_known && ({1'b0, len} > PB_17)) begin
                                r_in_pkt <= 1'b0;
                                r_status <= ldb_pkg::STAT_DROP;
                                r_kept   <= '0;
                                r_state  <= ST_EMIT;
                            end else begin
                                if (!r_len_known) begin
                                    r_exp <= len[CW-1:0];
                                end
                                if (cnt_after >= eff_exp) begin
                                    r_in_pkt    <= 1'b0;
                                    r_len_known <= 1'b0;
                                    r_state     <= ST_FIN;
                                end else begin
                                    r_len_known <= 1'b1;
                                end
                            end
                        end
                    end
                end
                ST_FIN: begin
                    r_kept <= '0;
                    if (chk != {r_b1, r_b0}) begin
                        r_err    <= r_err + 1'b1;
                        r_status <= ldb_pkg::STAT_CSUM;
                        r_state  <= ST_EMIT;
                    end else begin
                        r_status  <= ldb_pkg::STAT_OK;
                        r_clr_idx <= '0;
                        r_state   <= ST_CLR;
                    end
                end
                ST_INIT1: begin
                    r_num   <= div3_prod[31:17];
                    r_at    <= (CW+1)'(ldb_pkg::SAMPLE_START);
                    r_state <= ST_INIT2;
                end
                ST_INIT2: begin
                    r_step  <= step_c;
                    r_left  <= r_num;
                    r_state <= ST_SA;
                end
                ST_SA: begin
                    if (r_left != 15'd0 && (r_at + 2'd2 < {1'b0, r_count})) begin
                        r_state <= ST_SB;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_SB: r_state <= ST_SC;
                ST_SC: begin
                    r_inten <= r_pq;
                    r_state <= ST_SD;
                end
                ST_SD: begin
                    r_dlo   <= r_pq;
                    r_state <= ST_SE;
                end
                ST_SE: begin
                    if (keep) begin
                        r_kept <= r_kept + 1'b1;
                    end
                    r_at    <= r_at + 2'd3;
                    r_left  <= r_left - 1'b1;
                    r_state <= ST_SA;
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        r_o_kind    <= ldb_pkg::KIND_PKT;
                        r_o_status  <= r_status;
                        r_o_kept    <= r_kept;
                        r_o_err     <= r_err;
                        r_o_has     <= 1'b0;
                        r_o_dist    <= '0;
                        r_o_inten   <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_BRD: begin
                    if (slot_free) begin
                        r_o_kind    <= ldb_pkg::KIND_BIN;
                        r_o_status  <= ldb_pkg::STAT_OK;
                        r_o_kept    <= '0;
                        r_o_err     <= r_err;
                        r_o_has     <= r_bidx_ok && r_bq[24];
                        r_o_dist    <= r_bidx_ok ? r_bq[23:8] : 16'd0;
                        r_o_inten   <= r_bidx_ok ? r_bq[7:0] : 8'd0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.result_kind      = r_o_kind;
    assign o_out.packet_status    = r_o_status;
    assign o_out.samples_accepted = r_o_kept;
    assign o_out.error_total      = r_o_err;
    assign o_out.bin_has_range    = r_o_has;
    assign o_out.bin_distance     = r_o_dist;
    assign o_out.bin_intensity    = r_o_inten;

`include "lidar_packet_deframer_binner_assert.svh"
    `LDB_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= PB_C)
    `LDB_ASSERT_IMP(a_open_below_exp, i_clk, i_rst_n, r_state == ST_IDLE && r_len_known, r_in_pkt && r_count < r_exp)
    `LDB_ASSERT_NXT(a_bin_read_next, i_clk, i_rst_n, acc_bin, r_state == ST_BRD)
    `LDB_ASSERT_IMP(a_keep_in_table, i_clk, i_rst_n, r_state == ST_SE && keep, {1'b0, bin} < NB_11)
    `LDB_ASSERT_NXT(a_csum_err_count, i_clk, i_rst_n, r_state == ST_FIN && chk != {r_b1, r_b0}, r_err == $past(r_err) + 32'd1)
endmodule
`default_nettype wire

[rtl/core/ldb_bin_step.sv]
// Angle to bin stepper: start angle divided by 100, then advanced per sample
`default_nettype none
module ldb_bin_step (
    input  wire logic                     i_clk,
    input  wire ldb_pkg::t_bs_ctl         i_ctl,
    input  wire logic [15:0]              i_start,
    input  wire logic [2:0]               i_step,
    output logic [ldb_pkg::BIN_W-1:0]     o_bin
);
    logic [33:0]               r_prod;
    logic [ldb_pkg::BIN_W-1:0] r_bin;
    logic [6:0]                r_rem;
    logic [ldb_pkg::BIN_W-1:0] quo;
    logic [16:0]               rem_full;
    logic [6:0]                rem_sum;

    assign quo      = r_prod[33:24];
    assign rem_full = {1'b0, i_start} - ({7'b0, quo} * 17'd100);
    assign rem_sum  = r_rem + {4'b0, i_step};
    assign o_bin    = r_bin;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= {18'b0, i_start} * {16'b0, ldb_pkg::DIV100_MUL};
        end
        if (i_ctl.split) begin
            r_bin <= quo;
            r_rem <= rem_full[6:0];
        end else if (i_ctl.adv) begin
            if (rem_sum >= ldb_pkg::CDEG) begin
                r_rem <= rem_sum - ldb_pkg::CDEG;
                r_bin <= r_bin + 1'b1;
            end else begin
                r_rem <= rem_sum;
            end
        end
    end
endmodule
`default_nettype wire
